/* rtl/smam_pkg.sv */
// ----------------------------------------------------------------------------
// smam_pkg
// Shared constants, types and codes of the sensor moving average monitor.
// ----------------------------------------------------------------------------
package smam_pkg;

  localparam int MAX_SENSORS   = 16;
  localparam int WINDOW_LENGTH = 5;

  localparam int DATA_W    = 16;
  localparam int ID_W      = 16;
  localparam int ENTRY_W   = 2 * ID_W;
  localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
  localparam int ROW_W     = WINDOW_LENGTH * DATA_W;
  localparam int SUM_W     = DATA_W + 1 + $clog2(WINDOW_LENGTH);
  localparam int WIN_CNT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [DATA_W-1:0] MIN_TEMP_RST = 16'sd2560;
  localparam logic signed [DATA_W-1:0] MAX_TEMP_RST = 16'sd6400;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_APPLIED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_MAP     = 1'b0,
    KIND_READING = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_TEMP = 1'b0,
    REG_MAX_TEMP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_SEARCH,
    MS_AVG,
    MS_RESULT
  } mon_state_t;

  typedef enum logic [2:0] {
    AV_IDLE,
    AV_SUM,
    AV_ABS,
    AV_MUL,
    AV_FIX
  } avg_state_t;

  // fill writes a row and marks it valid, otherwise the row is marked empty
  typedef struct packed {
    logic             en;
    logic             fill;
    logic [IDX_W-1:0] addr;
    logic [ROW_W-1:0] row;
  } win_wr_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] average;
  } avg_res_t;

endpackage

/* rtl/smam_in_if.sv */
// ----------------------------------------------------------------------------
// smam_in_if
// Input channel: map entries and temperature readings.
// ----------------------------------------------------------------------------
interface smam_in_if;
  import smam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ID_W-1:0]          dev_id;
  logic [ID_W-1:0]          room_id;
  logic signed [DATA_W-1:0] temperature;

  modport source (
    output valid, kind, dev_id, room_id, temperature,
    input  ready
  );

  modport sink (
    input  valid, kind, dev_id, room_id, temperature,
    output ready
  );

endinterface

/* rtl/smam_out_if.sv */
// ----------------------------------------------------------------------------
// smam_out_if
// Output channel: one result per input transaction.
// ----------------------------------------------------------------------------
interface smam_out_if;
  import smam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [ID_W-1:0]          room;
  logic signed [DATA_W-1:0] average;
  logic                     too_cold;
  logic                     too_hot;

  modport source (
    output valid, status, room, average, too_cold, too_hot,
    input  ready
  );

  modport sink (
    input  valid, status, room, average, too_cold, too_hot,
    output ready
  );

endinterface

/* rtl/smam_ram.sv */
// ----------------------------------------------------------------------------
// smam_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smam_ram #(
  parameter  int WIDTH  = 16,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/smam_window_store.sv */
// ----------------------------------------------------------------------------
// smam_window_store
// Reading windows, one row per sensor, with per-row valid bits so that a
// row not yet written reads as all zero.
// ----------------------------------------------------------------------------
module smam_window_store (
  input  logic                    clk,
  input  logic                    rst,
  input  smam_pkg::win_wr_t       wr,
  input  logic [smam_pkg::IDX_W-1:0] raddr,
  output logic [smam_pkg::ROW_W-1:0] rdata
);
  import smam_pkg::*;

  logic [MAX_SENSORS-1:0] row_valid;
  logic                   rd_valid;
  logic [ROW_W-1:0]       ram_rdata;

  smam_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SENSORS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en && wr.fill),
    .waddr (wr.addr),
    .wdata (wr.row),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= wr.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= row_valid[raddr];
    end
  end

  assign rdata = rd_valid ? ram_rdata : '0;

endmodule

/* rtl/smam_avg_unit.sv */
// ----------------------------------------------------------------------------
// smam_avg_unit
// Window sum over one element per cycle, then division by the window length
// through a reciprocal multiply and a one-step correction, toward zero.
// ----------------------------------------------------------------------------
module smam_avg_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [smam_pkg::ROW_W-1:0] row,
  output smam_pkg::avg_res_t         res
);
  import smam_pkg::*;

  localparam int ABS_W   = SUM_W;
  localparam int RECIP_W = ABS_W + 1;
  localparam int PROD_W  = ABS_W + RECIP_W;
  localparam int WL_W    = $clog2(WINDOW_LENGTH + 1);
  localparam int REM_W   = ABS_W + WL_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** ABS_W) / WINDOW_LENGTH);
  localparam logic [WL_W-1:0]    WL    = WL_W'(WINDOW_LENGTH);

  avg_state_t state, state_next;

  logic [ROW_W-1:0]         shreg;
  logic [WIN_CNT_W-1:0]     cnt;
  logic signed [SUM_W-1:0]  acc;
  logic                     neg;
  logic [ABS_W-1:0]         mag;
  logic [ABS_W-1:0]         quot;
  logic signed [DATA_W-1:0] average;
  logic                     done;

  logic [PROD_W-1:0] mul_full;
  logic [REM_W-1:0]  back_prod;
  logic [REM_W-1:0]  rem;
  logic [ABS_W-1:0]  q_fix;
  logic [ABS_W-1:0]  q_signed;
  logic              sum_last;

  assign sum_last  = (cnt == WIN_CNT_W'(WINDOW_LENGTH - 1));
  assign mul_full  = PROD_W'(mag) * PROD_W'(RECIP);
  assign back_prod = REM_W'(quot) * REM_W'(WL);
  assign rem       = REM_W'(mag) - back_prod;
  assign q_fix     = (rem >= REM_W'(WINDOW_LENGTH)) ? quot + ABS_W'(1) : quot;
  assign q_signed  = neg ? (~q_fix + ABS_W'(1)) : q_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == AV_FIX);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      AV_IDLE: if (start) state_next = AV_SUM;
      AV_SUM:  if (sum_last) state_next = AV_ABS;
      AV_ABS:  state_next = AV_MUL;
      AV_MUL:  state_next = AV_FIX;
      AV_FIX:  state_next = AV_IDLE;
      default: state_next = AV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      AV_IDLE: begin
        if (start) begin
          shreg <= row;
          acc   <= '0;
          cnt   <= '0;
        end
      end
      AV_SUM: begin
        acc   <= acc + SUM_W'($signed(shreg[DATA_W-1:0]));
        shreg <= shreg >> DATA_W;
        cnt   <= cnt + WIN_CNT_W'(1);
      end
      AV_ABS: begin
        neg <= acc[SUM_W-1];
        mag <= acc[SUM_W-1] ? ABS_W'(-acc) : ABS_W'(acc);
      end
      AV_MUL: begin
        quot <= mul_full[PROD_W-2:ABS_W];
      end
      AV_FIX: begin
        average <= $signed(q_signed[DATA_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  assign res.done    = done;
  assign res.average = average;

endmodule

/* rtl/sensor_moving_average_monitor_top.sv */
// ----------------------------------------------------------------------------
// sensor_moving_average_monitor_top
// Sensor table with per-sensor reading windows and average threshold flags.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, dev_id, room_id, temperature
//   out_ch   out  valid/ready    status, room, average, too_cold, too_hot
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// one transaction at a time; a map item goes from idle straight to its result
// a reading searches the table, then averages, then gives its result: the table
// search reads one entry per cycle, the sum one window element per cycle
// an unknown id searches every filled entry, then goes to its result
// synchronous reset clears the table fill count and all window valid bits
// a held result lets one more transaction run up to its result, then input stalls
// ----------------------------------------------------------------------------
module sensor_moving_average_monitor_top (
  input  logic                           clk,
  input  logic                           rst,
  smam_in_if.sink                        in_ch,
  smam_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [smam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smam_pkg::DATA_W-1:0]    cfg_data
);
  import smam_pkg::*;

  mon_state_t state, state_next;

  logic [CNT_W-1:0]         entry_count;
  logic [IDX_W-1:0]         idx;
  logic [ID_W-1:0]          sid;
  logic [DATA_W-1:0]        temp;
  status_t                  res_status;
  logic [ID_W-1:0]          res_room;
  logic signed [DATA_W-1:0] res_avg;
  logic                     res_full;
  logic signed [DATA_W-1:0] min_temp;
  logic signed [DATA_W-1:0] max_temp;

  logic                     out_valid;
  status_t                  out_status;
  logic [ID_W-1:0]          out_room;
  logic signed [DATA_W-1:0] out_average;
  logic                     out_cold;
  logic                     out_hot;

  logic              in_accept;
  logic              count_full;
  logic              match;
  logic              last;
  logic              applied;
  logic              out_free;
  logic              id_we;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] id_rdata;
  logic [ROW_W-1:0]  win_rdata;
  logic [ROW_W-1:0]  new_row;
  win_wr_t           win_wr;
  logic              avg_start;
  avg_res_t          avg_res;

  smam_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SENSORS)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata ({in_ch.dev_id, in_ch.room_id}),
    .raddr (rd_addr),
    .rdata (id_rdata)
  );

  smam_window_store u_windows (
    .clk   (clk),
    .rst   (rst),
    .wr    (win_wr),
    .raddr (rd_addr),
    .rdata (win_rdata)
  );

  smam_avg_unit u_avg (
    .clk   (clk),
    .rst   (rst),
    .start (avg_start),
    .row   (new_row),
    .res   (avg_res)
  );

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == MS_IDLE);
  assign count_full = (entry_count >= CNT_W'(MAX_SENSORS));
  assign match      = (id_rdata[ENTRY_W-1:ID_W] == sid);
  assign last       = ((CNT_W'(idx) + CNT_W'(1)) >= entry_count);
  assign new_row    = (win_rdata >> DATA_W) | (ROW_W'(temp) << (ROW_W - DATA_W));
  assign applied    = (res_status == ST_APPLIED);
  assign out_free   = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    id_we      = 1'b0;
    rd_addr    = '0;
    avg_start  = 1'b0;
    win_wr     = '0;
    unique case (state)
      MS_IDLE: begin
        if (in_accept) begin
          if (kind_t'(in_ch.kind) == KIND_MAP) begin
            if (!count_full) begin
              id_we       = 1'b1;
              win_wr.en   = 1'b1;
              win_wr.addr = entry_count[IDX_W-1:0];
            end
            state_next = MS_RESULT;
          end else if (entry_count == '0) begin
            state_next = MS_RESULT;
          end else begin
            state_next = MS_SEARCH;
          end
        end
      end
      MS_SEARCH: begin
        if (match) begin
          win_wr.en   = 1'b1;
          win_wr.fill = 1'b1;
          win_wr.addr = idx;
          win_wr.row  = new_row;
          avg_start   = 1'b1;
          state_next  = MS_AVG;
        end else if (last) begin
          state_next = MS_RESULT;
        end else begin
          rd_addr = idx + IDX_W'(1);
        end
      end
      MS_AVG: begin
        if (avg_res.done) state_next = MS_RESULT;
      end
      MS_RESULT: begin
        if (out_free) state_next = MS_IDLE;
      end
      default: state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      idx         <= '0;
    end else begin
      unique case (state)
        MS_IDLE: begin
          if (in_accept) begin
            idx <= '0;
            if (kind_t'(in_ch.kind) == KIND_MAP && !count_full) begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end
        end
        MS_SEARCH: begin
          if (!match && !last) idx <= idx + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MS_IDLE: begin
        if (in_accept) begin
          sid  <= in_ch.dev_id;
          temp <= in_ch.temperature;
          if (kind_t'(in_ch.kind) == KIND_MAP) begin
            res_status <= count_full ? ST_FULL : ST_ADDED;
          end else begin
            res_status <= ST_UNKNOWN;
          end
        end
      end
      MS_SEARCH: begin
        if (match) begin
          res_room <= id_rdata[ID_W-1:0];
          res_full <= (new_row[DATA_W-1:0] != '0);
        end
      end
      MS_AVG: begin
        if (avg_res.done) begin
          res_avg    <= avg_res.average;
          res_status <= ST_APPLIED;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == MS_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == MS_RESULT && out_free) begin
      out_status  <= res_status;
      out_room    <= applied ? res_room : '0;
      out_average <= applied ? res_avg : '0;
      out_cold    <= applied && res_full && (res_avg < min_temp);
      out_hot     <= applied && res_full && (res_avg > max_temp);
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.room     = out_room;
  assign out_ch.average  = out_average;
  assign out_ch.too_cold = out_cold;
  assign out_ch.too_hot  = out_hot;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= MIN_TEMP_RST;
      max_temp <= MAX_TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_TEMP: min_temp <= $signed(cfg_data);
        REG_MAX_TEMP: max_temp <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_SENSORS))
    else $error("entry count above table size");

  a_search_in_table: assert property (@(posedge clk) disable iff (rst)
    state == MS_SEARCH |-> CNT_W'(idx) < entry_count)
    else $error("search beyond filled entries");

  a_avg_done_state: assert property (@(posedge clk) disable iff (rst)
    avg_res.done |-> state == MS_AVG)
    else $error("average result outside average wait");

  a_no_data_unless_applied: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_APPLIED |->
      out_room == '0 && out_average == '0 && !out_cold && !out_hot)
    else $error("result data on a non-reading transaction");

endmodule

/* tb/sensor_moving_average_monitor_top_tb.sv */
// ----------------------------------------------------------------------------
// sensor_moving_average_monitor_top_tb
// Self-checking bench for the sensor moving average monitor. A directed table
// covers reset behavior, the field extremes, duplicate ids, unknown ids and
// the zero-oldest window case. Random traffic then runs under several
// threshold settings. Each untyped result is checked against an in-bench
// model of the sensor table, the windows and the thresholds. The sender works
// in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module sensor_moving_average_monitor_top_tb;
  import smam_pkg::*;

  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int ROW_COUNT    = 21;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    kind_t                    kind;
    logic [ID_W-1:0]          dev_id;
    logic [ID_W-1:0]          room_id;
    logic signed [DATA_W-1:0] temperature;
  } sensor_item_t;

  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          room;
    logic signed [DATA_W-1:0] average;
    logic                     too_cold;
    logic                     too_hot;
  } monitor_result_t;

  typedef struct packed {
    sensor_item_t    item;
    logic            typed;
    monitor_result_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  smam_in_if  in_ch ();
  smam_out_if out_ch ();

  sensor_moving_average_monitor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // sensor table model
  int                       lower_limit = MIN_TEMP_RST;
  int                       upper_limit = MAX_TEMP_RST;
  int                       table_fill  = 0;
  logic [ID_W-1:0]          table_ids   [MAX_SENSORS];
  logic [ID_W-1:0]          table_rooms [MAX_SENSORS];
  logic signed [DATA_W-1:0] sensor_windows [MAX_SENSORS][WINDOW_LENGTH];

  monitor_result_t pending_results [$];
  int              results_seen = 0;
  int              error_count  = 0;

  function automatic monitor_result_t update_sensor_table(input sensor_item_t it);
    monitor_result_t r;
    int              slot;
    bit              found;
    int              sum;
    int              avg;
    bit              full;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    if (it.kind == KIND_MAP) begin
      if (table_fill >= MAX_SENSORS) begin
        r.status = ST_FULL;
        return r;
      end
      table_ids[table_fill]   = it.dev_id;
      table_rooms[table_fill] = it.room_id;
      for (int w = 0; w < WINDOW_LENGTH; w++) sensor_windows[table_fill][w] = '0;
      table_fill++;
      r.status = ST_ADDED;
      return r;
    end
    for (int i = 0; i < table_fill; i++) begin
      if (!found && table_ids[i] == it.dev_id) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    sum = 0;
    for (int w = 0; w < WINDOW_LENGTH - 1; w++) begin
      sensor_windows[slot][w] = sensor_windows[slot][w+1];
      sum += sensor_windows[slot][w];
    end
    sensor_windows[slot][WINDOW_LENGTH-1] = it.temperature;
    sum += it.temperature;
    avg  = sum / WINDOW_LENGTH;
    full = sensor_windows[slot][0] != 0;
    r.status   = ST_APPLIED;
    r.room     = table_rooms[slot];
    r.average  = avg[DATA_W-1:0];
    r.too_cold = full && (avg < lower_limit);
    r.too_hot  = full && (avg > upper_limit);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] near_value(input int center);
    int v;
    v = int'($urandom_range(0, 600)) - 300 + center;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[DATA_W-1:0];
  endfunction

  function automatic sensor_item_t make_random_item();
    sensor_item_t it;
    int           pick;
    int           map_pct;
    pick           = $urandom_range(0, 99);
    map_pct        = (table_fill < MAX_SENSORS) ? 4 : 2;
    it.room_id     = ID_W'($urandom);
    it.dev_id      = ID_W'($urandom);
    case ($urandom_range(0, 9))
      0:       it.temperature = DATA_W'($urandom);
      1:       it.temperature = '0;
      2:       it.temperature = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3, 4, 5: it.temperature = near_value(lower_limit);
      6, 7, 8: it.temperature = near_value(upper_limit);
      default: it.temperature = DATA_W'(int'($urandom_range(0, 64)) - 32);
    endcase
    if (pick < map_pct) begin
      it.kind = KIND_MAP;
      if (table_fill > 0 && $urandom_range(0, 3) == 0)
        it.dev_id = table_ids[$urandom_range(0, table_fill - 1)];
    end else begin
      it.kind = KIND_READING;
      if (pick < 92 && table_fill > 0)
        it.dev_id = table_ids[$urandom_range(0, table_fill - 1)];
    end
    return it;
  endfunction

  task automatic send_item(input sensor_item_t it, input bit typed,
                           input monitor_result_t typed_result);
    monitor_result_t predicted;
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.dev_id      <= it.dev_id;
    in_ch.room_id     <= it.room_id;
    in_ch.temperature <= it.temperature;
    do @(posedge clk); while (!in_ch.ready);
    predicted = update_sensor_table(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic signed [DATA_W-1:0] lo,
                                  input logic signed [DATA_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_TEMP;
    cfg_data  <= lo;
    @(posedge clk);
    lower_limit = lo;
    cfg_index <= REG_MAX_TEMP;
    cfg_data  <= hi;
    @(posedge clk);
    upper_limit = hi;
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    error_count++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin : check_output
    monitor_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("status (no transaction expected)", -1, out_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", want.status, out_ch.status);
        if (out_ch.room !== want.room)
          report_mismatch("room", want.room, out_ch.room);
        if (out_ch.average !== want.average)
          report_mismatch("average", want.average, out_ch.average);
        if (out_ch.too_cold !== want.too_cold)
          report_mismatch("too_cold", want.too_cold, out_ch.too_cold);
        if (out_ch.too_hot !== want.too_hot)
          report_mismatch("too_hot", want.too_hot, out_ch.too_hot);
      end
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int tick;
    bit long_hold_done;
    out_ch.ready   = 1'b0;
    tick           = 0;
    long_hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (!long_hold_done && results_seen >= HOLD_AFTER) begin
          // long stall so the block fills up and holds off its input
          long_hold_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= (tick % 4 == 0);
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t rows [ROW_COUNT];
    int            burst_left;
    int            gap;
    int            lo;
    int            hi;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_MAP;
    in_ch.dev_id      = '0;
    in_ch.room_id     = '0;
    in_ch.temperature = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MIN_TEMP;
    cfg_data          = '0;
    rst               = 1'b1;
    for (int s = 0; s < MAX_SENSORS; s++)
      for (int w = 0; w < WINDOW_LENGTH; w++) sensor_windows[s][w] = '0;

    rows = '{
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh0000}, 1'b1,
        '{ST_UNKNOWN, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      '{'{KIND_MAP, 16'hffff, 16'hffff, 16'sh0000}, 1'b1,
        '{ST_ADDED, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      '{'{KIND_MAP, 16'h0000, 16'h0000, 16'sh0000}, 1'b1,
        '{ST_ADDED, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      '{'{KIND_MAP, 16'h1234, 16'habcd, 16'sh0000}, 1'b1,
        '{ST_ADDED, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      // duplicate id, never matched by readings
      '{'{KIND_MAP, 16'h1234, 16'h5555, 16'sh0000}, 1'b1,
        '{ST_ADDED, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      '{'{KIND_READING, 16'hffff, 16'h0000, 16'sh7fff}, 1'b0, '0},
      '{'{KIND_READING, 16'hffff, 16'h0000, 16'sh7fff}, 1'b0, '0},
      '{'{KIND_READING, 16'hffff, 16'h0000, 16'sh7fff}, 1'b0, '0},
      '{'{KIND_READING, 16'hffff, 16'h0000, 16'sh7fff}, 1'b0, '0},
      '{'{KIND_READING, 16'hffff, 16'h0000, 16'sh7fff}, 1'b1,
        '{ST_APPLIED, 16'hffff, 16'sh7fff, 1'b0, 1'b1}},
      '{'{KIND_READING, 16'h1234, 16'h0000, 16'sh8000}, 1'b0, '0},
      '{'{KIND_READING, 16'h4321, 16'hffff, 16'sh7fff}, 1'b1,
        '{ST_UNKNOWN, 16'h0000, 16'sh0000, 1'b0, 1'b0}},
      // zero oldest reading holds off the threshold check
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh0000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh8000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh8000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh8000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh8000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh8000}, 1'b1,
        '{ST_APPLIED, 16'h0000, 16'sh8000, 1'b1, 1'b0}},
      '{'{KIND_READING, 16'hffff, 16'hffff, 16'sh0000}, 1'b0, '0},
      '{'{KIND_READING, 16'h0000, 16'h0000, 16'sh0001}, 1'b0, '0},
      '{'{KIND_MAP, 16'hffff, 16'h0001, 16'sh0000}, 1'b1,
        '{ST_ADDED, 16'h0000, 16'sh0000, 1'b0, 1'b0}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROW_COUNT; r++)
      send_item(rows[r].item, rows[r].typed, rows[r].result);

    burst_left = 0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_all_results();
      case (ph)
        0: begin lo = MIN_TEMP_RST; hi = MAX_TEMP_RST; end
        1: begin lo = -32768; hi = 32767; end
        2: begin lo = 32767;  hi = -32768; end
        3: begin lo = 0;      hi = 0; end
        4: begin
          lo = int'($urandom_range(0, 4000)) - 1000;
          hi = lo + int'($urandom_range(0, 3000));
        end
        default: begin
          lo = $signed(16'($urandom));
          hi = $signed(16'($urandom));
        end
      endcase
      write_thresholds(DATA_W'(lo), DATA_W'(hi));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        send_item(make_random_item(), 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/smam_pkg.sv
rtl/smam_in_if.sv
rtl/smam_out_if.sv
rtl/smam_ram.sv
rtl/smam_window_store.sv
rtl/smam_avg_unit.sv
rtl/sensor_moving_average_monitor_top.sv
tb/sensor_moving_average_monitor_top_tb.sv
